FILE: design/snph_pkg.sv
package snph_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned SLOT_W  = 3;
    localparam int unsigned PORT_W  = 15;
    localparam int unsigned ACC_W   = 16;
    localparam int unsigned HASH_W  = 64;
    localparam int unsigned HALF_W  = 32;
    localparam int unsigned CHUNK_BITS = 12;
    localparam int unsigned CHUNKS     = 6;
    localparam int unsigned SCALED_W   = 22;
    localparam int unsigned RECIP_W    = 23;
    localparam int unsigned RECIP_SHIFT = 29;

    localparam logic [7:0]         BYTE_FACTOR = 8'd131;
    localparam logic [HASH_W-1:0]  GOLDEN_GAMMA = 64'h9E3779B97F4A7C15;
    localparam logic [HASH_W-1:0]  MIX_MUL_A    = 64'hBF58476D1CE4E5B9;
    localparam logic [HASH_W-1:0]  MIX_MUL_B    = 64'h94D049BB133111EB;
    localparam int unsigned        SHIFT_PRE    = 30;
    localparam int unsigned        SHIFT_MID    = 27;
    localparam int unsigned        SHIFT_POST   = 31;
    localparam logic [9:0]         PORT_SCALE   = 10'd677;
    // ceil(2^29 / 100): exact quotient for any value below 2^22
    localparam logic [RECIP_W-1:0] RECIP_100    = 23'd5368710;
    localparam logic [PORT_W-1:0]  PORT_BASE    = 15'd5001;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MA_LO,
        ST_MA_MID,
        ST_MA_HI,
        ST_XA,
        ST_MB_LO,
        ST_MB_MID,
        ST_MB_HI,
        ST_XB,
        ST_SCALE,
        ST_PORT
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_MUL_LO,
        OP_MUL_MID,
        OP_MUL_HI,
        OP_XOR,
        OP_SCALE,
        OP_PORT
    } t_dp_op;

    typedef struct packed {
        logic   in_ready;
        t_dp_op op;
        logic   second;
    } t_dp_cmd;

    typedef struct packed {
        logic in_valid;
        logic byte_zero;
        logic out_valid;
    } t_dp_sts;

endpackage

FILE: design/snph_if.sv
interface snph_in_if;
    logic                           valid;
    logic                           ready;
    logic [snph_pkg::BYTE_W-1:0]    name_byte;
    logic [snph_pkg::SLOT_W-1:0]    slot;

    modport source (output valid, output name_byte, output slot, input ready);
    modport sink   (input valid, input name_byte, input slot, output ready);
endinterface

interface snph_out_if;
    logic                           valid;
    logic                           ready;
    logic [snph_pkg::PORT_W-1:0]    port;

    modport source (output valid, output port, input ready);
    modport sink   (input valid, input port, output ready);
endinterface

FILE: design/snph_ctrl.sv
module snph_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  snph_pkg::t_dp_sts i_sts,
    output snph_pkg::t_dp_cmd o_cmd
);
    import snph_pkg::*;

    t_state r_state;
    t_state n_state;

    // hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequence the finalizer and port steps
    always_comb begin
        n_state      = r_state;
        o_cmd.in_ready = 1'b0;
        o_cmd.op     = OP_NONE;
        o_cmd.second = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                // a terminator waits until the previous result is taken
                o_cmd.in_ready = !(i_sts.out_valid && i_sts.byte_zero);
                if (i_sts.in_valid && o_cmd.in_ready && i_sts.byte_zero) begin
                    n_state = ST_MA_LO;
                end
            end
            ST_MA_LO:  begin o_cmd.op = OP_MUL_LO;  n_state = ST_MA_MID; end
            ST_MA_MID: begin o_cmd.op = OP_MUL_MID; n_state = ST_MA_HI;  end
            ST_MA_HI:  begin o_cmd.op = OP_MUL_HI;  n_state = ST_XA;     end
            ST_XA:     begin o_cmd.op = OP_XOR;     n_state = ST_MB_LO;  end
            ST_MB_LO: begin
                o_cmd.op = OP_MUL_LO; o_cmd.second = 1'b1; n_state = ST_MB_MID;
            end
            ST_MB_MID: begin
                o_cmd.op = OP_MUL_MID; o_cmd.second = 1'b1; n_state = ST_MB_HI;
            end
            ST_MB_HI: begin
                o_cmd.op = OP_MUL_HI; o_cmd.second = 1'b1; n_state = ST_XB;
            end
            ST_XB: begin
                o_cmd.op = OP_XOR; o_cmd.second = 1'b1; n_state = ST_SCALE;
            end
            ST_SCALE:  begin o_cmd.op = OP_SCALE; n_state = ST_PORT; end
            ST_PORT:   begin o_cmd.op = OP_PORT;  n_state = ST_IDLE; end
            default:   n_state = ST_IDLE;
        endcase
    end

endmodule

FILE: design/snph_dp.sv
module snph_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  snph_pkg::t_dp_cmd i_cmd,
    output snph_pkg::t_dp_sts o_sts,
    snph_in_if.sink           i_in,
    snph_out_if.source        o_out
);
    import snph_pkg::*;

    logic [ACC_W-1:0]    r_acc;
    logic [HASH_W-1:0]   r_x;
    logic [HASH_W-1:0]   r_p;
    logic [SLOT_W-1:0]   r_slot;
    logic [SCALED_W-1:0] r_scaled;
    logic                r_zero;
    logic [PORT_W-1:0]   r_port;
    logic                r_out_valid;

    logic                  w_accept;
    logic [HASH_W-1:0]     w_seed;
    logic [HALF_W-1:0]     w_mul_a;
    logic [HALF_W-1:0]     w_mul_b;
    logic [HASH_W-1:0]     w_prod;
    logic [HASH_W-1:0]     w_k;
    logic [HASH_W-1:0]     w_rest;
    logic [6:0]            w_shamt;
    logic [SCALED_W+RECIP_W-1:0] w_recip;
    logic [PORT_W-1:0]     w_quot;

    assign i_in.ready  = i_cmd.in_ready;
    assign w_accept    = i_in.valid && i_cmd.in_ready;
    assign o_sts.in_valid  = i_in.valid;
    assign o_sts.byte_zero = (i_in.name_byte == '0);
    assign o_sts.out_valid = r_out_valid;
    assign o_out.valid = r_out_valid;
    assign o_out.port  = r_port;

    // seed the finalizer from the accumulator; the first xor-shift is applied as r_x is loaded
    assign w_seed = {{(HASH_W-ACC_W){1'b0}}, r_acc} + GOLDEN_GAMMA;

    // share one 32x32 multiplier across the three partial products
    assign w_k     = i_cmd.second ? MIX_MUL_B : MIX_MUL_A;
    assign w_mul_a = (i_cmd.op == OP_MUL_HI) ? r_x[HASH_W-1:HALF_W] : r_x[HALF_W-1:0];
    assign w_mul_b = (i_cmd.op == OP_MUL_MID) ? w_k[HASH_W-1:HALF_W] : w_k[HALF_W-1:0];
    assign w_prod  = {{HALF_W{1'b0}}, w_mul_a} * {{HALF_W{1'b0}}, w_mul_b};

    // select the requested chunk
    assign w_shamt = 7'(r_slot) * 7'(CHUNK_BITS);
    assign w_rest  = r_x >> w_shamt;

    // divide by 100 through the reciprocal
    assign w_recip = {{RECIP_W{1'b0}}, r_scaled} * {{SCALED_W{1'b0}}, RECIP_100};
    assign w_quot  = w_recip[RECIP_SHIFT +: PORT_W];

    // update accumulator; clear it on the terminator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (w_accept) begin
            if (i_in.name_byte != '0) begin
                r_acc <= r_acc ^ (16'(i_in.name_byte) * 16'(BYTE_FACTOR));
            end else begin
                r_acc <= '0;
            end
        end
    end

    // run the hash and port arithmetic
    always_ff @(posedge i_clk) begin
        if (w_accept && i_in.name_byte == '0) begin
            r_x    <= w_seed ^ (w_seed >> SHIFT_PRE);
            r_slot <= i_in.slot;
        end else begin
            unique case (i_cmd.op)
                OP_MUL_LO:  r_p <= w_prod;
                OP_MUL_MID: r_p <= r_p + {w_prod[HALF_W-1:0], {HALF_W{1'b0}}};
                OP_MUL_HI:  r_p <= r_p + {w_prod[HALF_W-1:0], {HALF_W{1'b0}}};
                OP_XOR: begin
                    r_x <= r_p ^ (r_p >> (i_cmd.second ? SHIFT_POST : SHIFT_MID));
                end
                OP_SCALE: begin
                    r_zero   <= (r_slot >= SLOT_W'(CHUNKS)) || (w_rest == '0);
                    r_scaled <= SCALED_W'(w_rest[CHUNK_BITS-1:0]) * SCALED_W'(PORT_SCALE);
                end
                OP_PORT:    r_port <= r_zero ? '0 : w_quot + PORT_BASE;
                OP_NONE:    ;
                default:    ;
            endcase
        end
    end

    // hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_PORT) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

FILE: design/service_name_port_hash_unit.sv
// Service name to port hash.
// Input channel i_in carries one name byte per item together with a slot
// index; a zero byte ends the name and is the only item that yields a result.
// Output channel o_out carries the candidate port for the terminator's slot:
// 5001..32724; 0 for a slot past the chunks or whose remaining hash bits are 0.
// Nonzero bytes are taken one per cycle while the sequencer is idle and fold
// into a 16-bit accumulator. The terminator starts the finalizer: three
// xor-shift steps around two 64-bit multiplies, each built from three 32x32
// partial products on one shared multiplier, then chunk scaling and the
// divide by 100. No byte is accepted while the sequencer steps through the
// finalizer states; it returns to idle as the result is loaded.
// Nonzero bytes of the next name are accepted while a result waits; a
// terminator waits until the receiver has taken the previous result, which
// is held as long as o_out.ready stays low.
// Reset clears the accumulator, returns the sequencer to idle and drops any
// pending result.
module service_name_port_hash_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    snph_in_if.sink     i_in,
    snph_out_if.source  o_out
);
    import snph_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    snph_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    snph_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

FILE: tb/port_hash_checker.sv
`timescale 1ns / 1ps

module port_hash_checker (
    input  logic    i_clk,
    input  logic    i_rst_n,
    snph_in_if      i_in_mon,
    snph_out_if     i_out_mon,
    output int      o_fail_count,
    output int      o_pending
);
    import snph_pkg::*;

    localparam int MAX_REPORTS = 10;

    logic [ACC_W-1:0]  name_acc;
    logic [PORT_W-1:0] expected_ports[$];
    int                fail_count;

    // Run the 64-bit finalizer on the accumulator plus the golden-ratio step
    function automatic logic [HASH_W-1:0] mix_name_hash(input logic [ACC_W-1:0] acc);
        logic [HASH_W-1:0] x;
        x = {{(HASH_W-ACC_W){1'b0}}, acc} + GOLDEN_GAMMA;
        x = x ^ (x >> SHIFT_PRE);
        x = x * MIX_MUL_A;
        x = x ^ (x >> SHIFT_MID);
        x = x * MIX_MUL_B;
        x = x ^ (x >> SHIFT_POST);
        return x;
    endfunction

    // Pick the chunk of the requested slot and scale it into the port range
    function automatic logic [PORT_W-1:0] port_for_name(input logic [ACC_W-1:0] acc,
                                                         input logic [SLOT_W-1:0] slot);
        logic [HASH_W-1:0] rest;
        int unsigned       chunk;
        int unsigned       port_val;
        if (slot >= CHUNKS)
            return '0;
        rest = mix_name_hash(acc) >> (CHUNK_BITS * slot);
        if (rest == '0)
            return '0;
        chunk    = int'(rest[CHUNK_BITS-1:0]);
        port_val = (chunk * 677) / 100 + 5001;
        return port_val[PORT_W-1:0];
    endfunction

    // Fold accepted bytes, queue a port on each terminator, compare results
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            name_acc <= '0;
            expected_ports.delete();
            fail_count <= 0;
        end else begin
            if (i_in_mon.valid && i_in_mon.ready) begin
                if (i_in_mon.name_byte != '0) begin
                    name_acc <= name_acc ^ (ACC_W'(i_in_mon.name_byte) * ACC_W'(BYTE_FACTOR));
                end else begin
                    expected_ports.push_back(port_for_name(name_acc, i_in_mon.slot));
                    name_acc <= '0;
                end
            end
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (expected_ports.size() == 0) begin
                    if (fail_count < MAX_REPORTS)
                        $display("%0t: unexpected port %0d with nothing pending",
                                 $realtime, i_out_mon.port);
                    fail_count <= fail_count + 1;
                end else begin
                    if (i_out_mon.port !== expected_ports[0]) begin
                        if (fail_count < MAX_REPORTS)
                            $display("%0t: port mismatch: expected %0d, got %0d",
                                     $realtime, expected_ports[0], i_out_mon.port);
                        fail_count <= fail_count + 1;
                    end
                    void'(expected_ports.pop_front());
                end
            end
        end
    end

    assign o_fail_count = fail_count;
    assign o_pending    = expected_ports.size();

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import snph_pkg::*;

    localparam int RANDOM_ITEMS  = 1000;
    localparam int RANDOM_PHASES = 8;
    localparam int DRAIN_CYCLES  = 20;

    logic i_clk;
    logic i_rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   fail_count;
    int   pending;

    snph_in_if  in_ch ();
    snph_out_if out_ch ();

    service_name_port_hash_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    port_hash_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Stall the result channel at the current phase's rate
    always @(posedge i_clk) begin
        if (!i_rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Offer one item, with random idle cycles ahead of it, and hold until taken
    task automatic send_byte(input logic [BYTE_W-1:0] name_byte,
                             input logic [SLOT_W-1:0] slot);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid     <= 1'b0;
            in_ch.name_byte <= BYTE_W'($urandom);
            in_ch.slot      <= SLOT_W'($urandom);
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.name_byte <= name_byte;
        in_ch.slot      <= slot;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Drop valid and hold off until every queued port has come back
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Random name of mostly short length, then its terminator
    task automatic send_random_name(inout int sent);
        int name_len;
        if ($urandom_range(9) == 0)
            name_len = $urandom_range(24);
        else
            name_len = $urandom_range(6);
        repeat (name_len) begin
            send_byte(BYTE_W'($urandom_range(255, 1)), SLOT_W'($urandom));
            sent++;
        end
        send_byte('0, SLOT_W'($urandom));
        sent++;
    endtask

    initial begin
        int sent;
        int phase;
        in_ch.valid     <= 1'b0;
        in_ch.name_byte <= '0;
        in_ch.slot      <= '0;
        i_rst_n         <= 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty names over every slot, including the two past the last chunk
        for (int s = 0; s < 8; s++)
            send_byte('0, SLOT_W'(s));
        // Extreme bytes and a name that cancels back to an empty accumulator
        send_byte(8'hFF, 3'd7);
        send_byte('0, 3'd0);
        send_byte(8'h01, 3'd0);
        send_byte('0, 3'd5);
        send_byte(8'hFF, 3'd2);
        send_byte(8'hFF, 3'd5);
        send_byte('0, 3'd3);
        send_byte(8'h80, 3'd1);
        send_byte(8'h01, 3'd6);
        send_byte(8'h7F, 3'd4);
        send_byte('0, 3'd2);
        send_byte(8'h55, 3'd3);
        send_byte(8'hAA, 3'd0);
        send_byte('0, 3'd4);
        send_byte(8'hFE, 3'd1);
        send_byte('0, 3'd6);
        drain_results();

        // Cycle through the idling modes, draining between phases
        sent = 0;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            while (sent < (RANDOM_ITEMS * (phase + 1)) / RANDOM_PHASES)
                send_random_name(sent);
            drain_results();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("PASS service_name_port_hash_unit");
        end else begin
            $display("FAIL service_name_port_hash_unit");
        end
        $finish;
    end

    // Give up well past the slowest legal run
    initial begin
        #5_000_000;
        $display("FAIL service_name_port_hash_unit");
        $finish;
    end

endmodule

FILE: files.f
design/snph_pkg.sv
design/snph_if.sv
design/snph_ctrl.sv
design/snph_dp.sv
design/service_name_port_hash_unit.sv
tb/port_hash_checker.sv
tb/tb.sv
